[hdl/plnc_pkg.sv]
// Package for the periodic lattice neighbour counter.
// Holds request/response payload types, command and offset codes, and
// the controller/datapath handshake structs. No dependencies.
`default_nettype none

package plnc_pkg;

  localparam int unsigned CoordW = 5;
  localparam int unsigned CountW = 5;
  localparam int unsigned TotalW = 16;
  localparam int unsigned EntryW = CountW + 1;
  localparam int unsigned NbNum  = 26;
  localparam int unsigned NbIdxW = 5;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_DELETE = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    TRIT_DEC  = 2'd0,
    TRIT_KEEP = 2'd1,
    TRIT_INC  = 2'd2
  } trit_e;

  typedef struct packed {
    trit_e dx;
    trit_e dy;
    trit_e dz;
  } offset_t;

  // all 26 neighbour offsets in x-major order, centre skipped
  localparam offset_t NbOffset [NbNum] = '{
    6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09, 6'h0A,
    6'h10, 6'h11, 6'h12, 6'h14,        6'h16, 6'h18, 6'h19, 6'h1A,
    6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A
  };

  typedef struct packed {
    logic [1:0]        command;
    logic [CoordW-1:0] site_x;
    logic [CoordW-1:0] site_y;
    logic [CoordW-1:0] site_z;
  } req_t;

  typedef struct packed {
    logic              site_occupied;
    logic [CountW-1:0] neighbour_count;
    logic [TotalW-1:0] total_occupied;
    logic              status;
  } rsp_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd_center;
    logic decide;
    logic nb_rd;
    logic nb_wr;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic change;
    logic nb_last;
  } ctl_stat_t;

endpackage

`default_nettype wire

[hdl/plnc_if.sv]
// Request and response channel interfaces (valid/ready with payload).
// Depends on plnc_pkg for the payload types.
`default_nettype none

interface plnc_req_if;
  import plnc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plnc_rsp_if;
  import plnc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/plnc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plnc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/plnc_ctrl.sv]
// Controller state machine: clearing pass, centre lookup, neighbour
// read-modify-write sequence and response hand-off. Depends on plnc_pkg.
`default_nettype none

module plnc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  input  wire plnc_pkg::ctl_stat_t  stat_i,
  output plnc_pkg::ctl_cmd_t        cmd_o
);
  import plnc_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDC  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_NBR  = 3'd4;
  localparam logic [2:0] S_NBW  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  ctl_cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_RDC;
        end
      end
      S_RDC: begin
        cmd.rd_center = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (stat_i.change) begin
          cmd.nb_rd = 1'b1;
          state_d   = S_NBR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_NBR: begin
        cmd.nb_wr = 1'b1;
        cmd.nb_rd = 1'b1;
        if (stat_i.nb_last) begin
          state_d = S_NBW;
        end
      end
      S_NBW: begin
        cmd.nb_wr = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.out_load | (out_valid_q & ~rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

[hdl/plnc_dpath.sv]
// Datapath: coordinate reduction, site RAM (occupancy and neighbour count),
// neighbour address generation, occupied total and response register.
// Depends on plnc_pkg and plnc_ram.
`default_nettype none

module plnc_dpath #(
  parameter int unsigned SIZE_X = 32,
  parameter int unsigned SIZE_Y = 32,
  parameter int unsigned SIZE_Z = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire plnc_pkg::req_t      req_i,
  input  wire plnc_pkg::ctl_cmd_t  cmd_i,
  output plnc_pkg::ctl_stat_t      stat_o,
  output plnc_pkg::rsp_t           rsp_o
);
  import plnc_pkg::*;

  localparam int unsigned XWidth = $clog2(SIZE_X);
  localparam int unsigned YWidth = $clog2(SIZE_Y);
  localparam int unsigned ZWidth = $clog2(SIZE_Z);
  localparam int unsigned AddrW  = XWidth + YWidth + ZWidth;
  localparam int unsigned Depth  = 2 ** AddrW;
  localparam int unsigned Sites  = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int unsigned TotW   = $clog2(Sites + 1);
  localparam int unsigned InNum  = 2 ** CoordW;
  localparam logic [7:0]  LastX  = 8'(SIZE_X - 1);
  localparam logic [7:0]  LastY  = 8'(SIZE_Y - 1);
  localparam logic [7:0]  LastZ  = 8'(SIZE_Z - 1);

  function automatic logic [7:0] wrap_step(logic [7:0] c, trit_e d, logic [7:0] last);
    logic [7:0] r;
    case (d)
      TRIT_DEC: r = (c == 8'd0) ? last : c - 8'd1;
      TRIT_INC: r = (c == last) ? 8'd0 : c + 8'd1;
      default:  r = c;
    endcase
    return r;
  endfunction

  // coordinate modulo lattice size, as constant lookup
  logic [XWidth-1:0] xmod [InNum];
  logic [YWidth-1:0] ymod [InNum];
  logic [ZWidth-1:0] zmod [InNum];

  for (genvar i = 0; i < InNum; i++) begin : g_mod
    localparam int unsigned ValX = i % SIZE_X;
    localparam int unsigned ValY = i % SIZE_Y;
    localparam int unsigned ValZ = i % SIZE_Z;
    assign xmod[i] = XWidth'(ValX);
    assign ymod[i] = YWidth'(ValY);
    assign zmod[i] = ZWidth'(ValZ);
  end

  logic [1:0]        cmd_q;
  logic [XWidth-1:0] x_q;
  logic [YWidth-1:0] y_q;
  logic [ZWidth-1:0] z_q;
  logic              occ_q;
  logic [CountW-1:0] cnt_q;
  logic              st_q;
  logic [TotW-1:0]   total_q, total_d;
  logic [NbIdxW-1:0] nb_idx_q;
  logic [AddrW-1:0]  nb_addr_q;
  logic [AddrW-1:0]  clr_q;
  rsp_t              rsp_q;

  offset_t           ofs;
  logic [XWidth-1:0] nx;
  logic [YWidth-1:0] ny;
  logic [ZWidth-1:0] nz;
  logic [AddrW-1:0]  nb_addr;
  logic [AddrW-1:0]  center_addr;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic              rd_occ;
  logic [CountW-1:0] rd_cnt;
  logic [CountW-1:0] cnt_adj;
  logic              is_create;
  logic              is_delete;
  logic              change;
  logic [31:0]       total_ext;
  logic [TotalW-1:0] total_sat;

  assign ofs         = NbOffset[nb_idx_q];
  assign nx          = XWidth'(wrap_step(8'(x_q), ofs.dx, LastX));
  assign ny          = YWidth'(wrap_step(8'(y_q), ofs.dy, LastY));
  assign nz          = ZWidth'(wrap_step(8'(z_q), ofs.dz, LastZ));
  assign nb_addr     = {nx, ny, nz};
  assign center_addr = {x_q, y_q, z_q};

  assign rd_occ    = ram_rdata[CountW];
  assign rd_cnt    = ram_rdata[CountW-1:0];
  assign is_create = (cmd_q == CMD_CREATE);
  assign is_delete = (cmd_q == CMD_DELETE);
  assign change    = (is_create & ~rd_occ) | (is_delete & rd_occ);

  always_comb begin
    if (is_create) begin
      cnt_adj = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + CountW'(1);
    end else begin
      cnt_adj = (rd_cnt == '0) ? rd_cnt : rd_cnt - CountW'(1);
    end
  end

  assign ram_we = cmd_i.clr_wr | (cmd_i.decide & change) | cmd_i.nb_wr;

  always_comb begin
    if (cmd_i.clr_wr) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.nb_wr) begin
      ram_waddr = nb_addr_q;
      ram_wdata = {rd_occ, cnt_adj};
    end else begin
      ram_waddr = center_addr;
      ram_wdata = {~rd_occ, rd_cnt};
    end
  end

  assign ram_raddr = cmd_i.nb_rd ? nb_addr : center_addr;

  plnc_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    total_d = total_q;
    if (cmd_i.decide && change) begin
      if (is_create) begin
        total_d = total_q + TotW'(1);
      end else if (total_q != '0) begin
        total_d = total_q - TotW'(1);
      end
    end
  end

  assign total_ext = 32'(total_q);
  assign total_sat = (total_ext > 32'h0000_FFFF) ? '1 : total_ext[TotalW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      nb_idx_q <= '0;
      clr_q    <= '0;
    end else begin
      total_q <= total_d;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.load) begin
        nb_idx_q <= '0;
      end else if (cmd_i.nb_rd) begin
        nb_idx_q <= nb_idx_q + NbIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_i.command;
      x_q   <= xmod[req_i.site_x];
      y_q   <= ymod[req_i.site_y];
      z_q   <= zmod[req_i.site_z];
    end
    if (cmd_i.decide) begin
      occ_q <= rd_occ ^ change;
      cnt_q <= rd_cnt;
      st_q  <= (is_create | is_delete) & ~change;
    end
    if (cmd_i.nb_rd) begin
      nb_addr_q <= nb_addr;
    end
    if (cmd_i.out_load) begin
      rsp_q.site_occupied   <= occ_q;
      rsp_q.neighbour_count <= cnt_q;
      rsp_q.total_occupied  <= total_sat;
      rsp_q.status          <= st_q;
    end
  end

  assign stat_o.clr_last = (clr_q == '1);
  assign stat_o.change   = change;
  assign stat_o.nb_last  = (nb_idx_q == NbIdxW'(NbNum - 1));
  assign rsp_o           = rsp_q;

endmodule

`default_nettype wire

[hdl/periodic_lattice_neighbour_counter_unit.sv]
// Top level of the periodic lattice neighbour counter.
// Depends on plnc_pkg, plnc_if, plnc_ctrl, plnc_dpath and plnc_ram.
//
// Each request names a site and a query, create or delete command and yields
// exactly one response with the site's occupancy, its count of occupied
// periodic neighbours, the lattice-wide occupied total (saturating at 65535)
// and an ignored flag. Sites live in one single-port-write RAM holding the
// occupancy bit and 5-bit neighbour count, addressed by the concatenated
// coordinates. After reset the block sweeps this RAM to zero, one entry per
// cycle, over all 2**(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z)) entries
// (32768 at the default size) and takes no request meanwhile. A query, or an
// ignored create/delete, passes the centre read, decide and finish states; a
// create or delete that changes the site also makes the 26 neighbour
// read-modify-write updates through the RAM, one per cycle.
// One request is processed at a time; a new one is taken while the previous
// response still waits in the output register.
`default_nettype none

module periodic_lattice_neighbour_counter_unit #(
  parameter int unsigned SIZE_X = 32,
  parameter int unsigned SIZE_Y = 32,
  parameter int unsigned SIZE_Z = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  plnc_req_if.sink    req_i,
  plnc_rsp_if.source  rsp_o
);
  import plnc_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      req_ready;
  logic      rsp_valid;
  rsp_t      rsp_data;

  plnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plnc_dpath #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .SIZE_Z (SIZE_Z)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i.data),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule

`default_nettype wire

[hdl/plnc_checker.sv]
// Port-level checker for the neighbour counter, bound to the top level.
// Depends on plnc_pkg; tracks commands of requests awaiting a response.
`default_nettype none

module plnc_checker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire logic            req_ready_i,
  input  wire logic [1:0]      req_command_i,
  input  wire logic            rsp_valid_i,
  input  wire logic            rsp_ready_i,
  input  wire plnc_pkg::rsp_t  rsp_data_i
);
  import plnc_pkg::*;

  logic       push;
  logic       pop;
  logic [1:0] pend_cnt_q;
  logic [1:0] head_q;
  logic [1:0] tail_q;

  assign push = req_valid_i & req_ready_i;
  assign pop  = rsp_valid_i & rsp_ready_i & (pend_cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
      head_q     <= 2'd0;
      tail_q     <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (pend_cnt_q == 2'd0) begin
            head_q <= req_command_i;
          end else begin
            tail_q <= req_command_i;
          end
          pend_cnt_q <= pend_cnt_q + 2'd1;
        end
        2'b01: begin
          head_q     <= tail_q;
          pend_cnt_q <= pend_cnt_q - 2'd1;
        end
        2'b11: begin
          if (pend_cnt_q == 2'd1) begin
            head_q <= req_command_i;
          end else begin
            head_q <= tail_q;
            tail_q <= req_command_i;
          end
        end
        default: begin
          pend_cnt_q <= pend_cnt_q;
        end
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response dropped or changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_cnt_q != 2'd0)
    else $error("response without an outstanding request");

  a_create_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && head_q == CMD_CREATE |-> rsp_data_i.site_occupied)
    else $error("site vacant after create");

  a_delete_vac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && head_q == CMD_DELETE |-> !rsp_data_i.site_occupied)
    else $error("site occupied after delete");

  a_query_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && head_q != CMD_CREATE && head_q != CMD_DELETE
      |-> !rsp_data_i.status)
    else $error("ignored flag on a query");

endmodule

bind periodic_lattice_neighbour_counter_unit plnc_checker u_plnc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_command_i (req_i.data.command),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_data_i    (rsp_o.data)
);

`default_nettype wire
